[sv/dual_motor_pwm_slew_commander_defines.svh]
// assertion macros shared by the motor commander checker
`ifndef DUAL_MOTOR_PWM_SLEW_COMMANDER_DEFINES_SVH
`define DUAL_MOTOR_PWM_SLEW_COMMANDER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DMPSC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dmpsc check failed");

// next-cycle implication, sampled on clk, off during reset
`define DMPSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dmpsc check failed");

`endif

[sv/dmpsc_pkg.sv]
// types, constants and helper functions of the dual motor commander
package dmpsc_pkg;

	// operation codes carried by an input transaction
	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_SET_LEFT  = 3'd1,
		OP_SET_RIGHT = 3'd2,
		OP_SET_BOTH  = 3'd3,
		OP_TWIST     = 3'd4,
		OP_STOP      = 3'd5,
		OP_BRAKE     = 3'd6,
		OP_ENABLE    = 3'd7
	} op_t;

	// signed channel command, -255..255
	typedef logic signed [8:0] cmd_t;

	// one channel's pin levels
	typedef struct packed {
		logic       fwd;
		logic [7:0] duty;
	} pin_t;

	// full result as shown on the output channel
	typedef struct packed {
		logic standby;
		pin_t left;
		pin_t right;
	} pins_t;

	localparam cmd_t CMD_MAX = 9'sd255;
	localparam cmd_t CMD_MIN = -9'sd255;
	localparam logic signed [17:0] CMD_MAX_W = 18'sd255;
	localparam logic signed [17:0] CMD_MIN_W = -18'sd255;
	localparam logic [7:0] RAMP_RESET = 8'd255;
	localparam logic [7:0] RAMP_MIN   = 8'd1;
	localparam logic [7:0] DUTY_FULL  = 8'hFF;

	// reciprocal of ten for 16-bit magnitudes: q = (x * 52429) >> 19
	localparam logic [15:0] DIV10_RECIP = 16'd52429;
	localparam int DIV10_SHIFT = 19;

	// saturate a wide signed value to the command range
	function automatic cmd_t clamp_cmd(input logic signed [17:0] v);
		cmd_t r;
		if (v > CMD_MAX_W) begin
			r = CMD_MAX;
		end else if (v < CMD_MIN_W) begin
			r = CMD_MIN;
		end else begin
			r = v[8:0];
		end
		return r;
	endfunction

	// sign-magnitude pin levels for a command, zero gives low direction
	function automatic pin_t drive(input cmd_t c);
		pin_t p;
		cmd_t m;
		m = c[8] ? -c : c;
		p.fwd = !c[8] && (c != 9'sd0);
		p.duty = m[7:0];
		return p;
	endfunction

endpackage

[sv/dmpsc_item_if.sv]
// input channel: operation and two signed values
interface dmpsc_item_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic signed [15:0] first_value;
	logic signed [15:0] second_value;

	modport source(output valid, output operation, output first_value,
		output second_value, input ready);
	modport sink(input valid, input operation, input first_value,
		input second_value, output ready);
endinterface

[sv/dmpsc_result_if.sv]
// result channel: standby and both channels' pin levels
interface dmpsc_result_if;
	logic       valid;
	logic       ready;
	logic       standby_on;
	logic       left_forward;
	logic [7:0] left_duty;
	logic       right_forward;
	logic [7:0] right_duty;

	modport source(output valid, output standby_on, output left_forward,
		output left_duty, output right_forward, output right_duty, input ready);
	modport sink(input valid, input standby_on, input left_forward,
		input left_duty, input right_forward, input right_duty, output ready);
endinterface

[sv/dmpsc_cfg_if.sv]
// configuration write channel for the ramp step
interface dmpsc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[sv/dmpsc_slew.sv]
// one channel's slew step: move current toward target by at most the ramp step
module dmpsc_slew (
	input  dmpsc_pkg::cmd_t cur,
	input  dmpsc_pkg::cmd_t tgt,
	input  logic [7:0]      ramp,
	output dmpsc_pkg::cmd_t nxt
);

	logic signed [9:0] diff;
	logic [9:0]        mag;
	logic signed [9:0] ramp_w;
	logic signed [9:0] stepped;

	// difference and its magnitude, at most 510
	assign diff   = 10'(tgt) - 10'(cur);
	assign mag    = diff[9] ? 10'(-diff) : 10'(diff);
	assign ramp_w = $signed({2'b00, ramp});

	// one ramp step toward target, stays in range since the gap is wider
	assign stepped = diff[9] ? (10'(cur) - ramp_w) : (10'(cur) + ramp_w);

	// snap onto target once within reach
	assign nxt = (mag <= {2'b00, ramp}) ? tgt : stepped[8:0];

endmodule

[sv/dual_motor_pwm_slew_commander.sv]
// top level of the dual motor PWM slew commander
// Takes one operation per transaction and returns the pin levels it leaves,
// one result per item. An item is taken into an input register and worked
// against the command state into a result register once that register is
// free or draining, and one item can enter every cycle while results are
// taken; the rate is set by that single stage of clamp, add and compare logic,
// with one 16 x 16 multiply for the twist rate. A result that is not taken
// holds the stage, and input ready drops only when both the input and result
// registers are full and the result is stalled. The ramp step register is
// written through its own channel, always ready; a write of zero is stored
// as one.
module dual_motor_pwm_slew_commander (
	input  logic                  clk,
	input  logic                  arst_n,
	dmpsc_item_if.sink            item,
	dmpsc_result_if.source        result,
	dmpsc_cfg_if.sink             cfg
);

	// input register
	logic               vld_s1;
	dmpsc_pkg::op_t     op_s1;
	logic signed [15:0] a_s1;
	logic signed [15:0] b_s1;

	// command state
	dmpsc_pkg::cmd_t l_tgt_q, r_tgt_q, l_cur_q, r_cur_q;
	logic            en_q;
	dmpsc_pkg::pin_t l_pin_q, r_pin_q;
	logic [7:0]      ramp_q;

	// result register
	logic             res_vld_q;
	dmpsc_pkg::pins_t res_q;

	// next state
	dmpsc_pkg::cmd_t l_tgt_d, r_tgt_d, l_cur_d, r_cur_d;
	logic            en_d;
	dmpsc_pkg::pin_t l_pin_d, r_pin_d;

	logic out_free;
	logic adv;

	// twist arithmetic
	logic signed [16:0] a_bias;
	logic signed [16:0] lin;
	logic [15:0]        b_mag;
	logic [31:0]        prod;
	logic [12:0]        quot;
	logic signed [17:0] ang;
	logic signed [17:0] tw_l, tw_r;
	dmpsc_pkg::cmd_t    a_clamp, b_clamp, tw_l_clamp, tw_r_clamp;
	dmpsc_pkg::cmd_t    l_slew, r_slew;

	// handshake: the stage moves when the result register is free or draining
	assign out_free   = !res_vld_q || result.ready;
	assign adv        = vld_s1 && out_free;
	assign item.ready = !vld_s1 || out_free;
	assign cfg.ready  = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1 <= dmpsc_pkg::op_t'(item.operation);
			a_s1  <= item.first_value;
			b_s1  <= item.second_value;
		end
	end

	// ramp step register, zero saturates to one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q <= dmpsc_pkg::RAMP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			ramp_q <= (cfg.data == 8'd0) ? dmpsc_pkg::RAMP_MIN : cfg.data;
		end
	end

	// truncating halve of v: add one when negative before the shift
	assign a_bias = {a_s1[15], a_s1} + {16'd0, a_s1[15]};
	assign lin    = a_bias >>> 1;

	// truncating tenth of omega through the reciprocal on the magnitude
	assign b_mag = b_s1[15] ? 16'(-b_s1) : 16'(b_s1);
	assign prod  = 32'(b_mag) * 32'(dmpsc_pkg::DIV10_RECIP);
	assign quot  = prod[dmpsc_pkg::DIV10_SHIFT +: 13];
	assign ang   = b_s1[15] ? -$signed({5'd0, quot}) : $signed({5'd0, quot});

	assign tw_l = 18'(lin) - ang;
	assign tw_r = 18'(lin) + ang;

	// clamped commands
	assign a_clamp    = dmpsc_pkg::clamp_cmd(18'(a_s1));
	assign b_clamp    = dmpsc_pkg::clamp_cmd(18'(b_s1));
	assign tw_l_clamp = dmpsc_pkg::clamp_cmd(tw_l);
	assign tw_r_clamp = dmpsc_pkg::clamp_cmd(tw_r);

	// slew units, one per channel
	dmpsc_slew u_slew_l (
		.cur  (l_cur_q),
		.tgt  (l_tgt_q),
		.ramp (ramp_q),
		.nxt  (l_slew)
	);

	dmpsc_slew u_slew_r (
		.cur  (r_cur_q),
		.tgt  (r_tgt_q),
		.ramp (ramp_q),
		.nxt  (r_slew)
	);

	// operation decode and next state
	always_comb begin
		l_tgt_d = l_tgt_q;
		r_tgt_d = r_tgt_q;
		l_cur_d = l_cur_q;
		r_cur_d = r_cur_q;
		en_d    = en_q;
		l_pin_d = l_pin_q;
		r_pin_d = r_pin_q;
		unique case (op_s1)
			dmpsc_pkg::OP_TICK: begin
				if (en_q) begin
					l_cur_d = l_slew;
					r_cur_d = r_slew;
					l_pin_d = dmpsc_pkg::drive(l_slew);
					r_pin_d = dmpsc_pkg::drive(r_slew);
				end
			end
			dmpsc_pkg::OP_SET_LEFT: begin
				l_tgt_d = a_clamp;
			end
			dmpsc_pkg::OP_SET_RIGHT: begin
				r_tgt_d = b_clamp;
			end
			dmpsc_pkg::OP_SET_BOTH: begin
				en_d    = 1'b1;
				l_tgt_d = a_clamp;
				r_tgt_d = b_clamp;
				l_cur_d = a_clamp;
				r_cur_d = b_clamp;
				l_pin_d = dmpsc_pkg::drive(a_clamp);
				r_pin_d = dmpsc_pkg::drive(b_clamp);
			end
			dmpsc_pkg::OP_TWIST: begin
				en_d    = 1'b1;
				l_tgt_d = tw_l_clamp;
				r_tgt_d = tw_r_clamp;
				l_cur_d = tw_l_clamp;
				r_cur_d = tw_r_clamp;
				l_pin_d = dmpsc_pkg::drive(tw_l_clamp);
				r_pin_d = dmpsc_pkg::drive(tw_r_clamp);
			end
			dmpsc_pkg::OP_STOP: begin
				en_d         = 1'b0;
				l_tgt_d      = '0;
				r_tgt_d      = '0;
				l_cur_d      = '0;
				r_cur_d      = '0;
				l_pin_d.duty = 8'd0;
				r_pin_d.duty = 8'd0;
			end
			dmpsc_pkg::OP_BRAKE: begin
				en_d    = 1'b0;
				l_tgt_d = '0;
				r_tgt_d = '0;
				l_cur_d = '0;
				r_cur_d = '0;
				l_pin_d = '{fwd: 1'b1, duty: dmpsc_pkg::DUTY_FULL};
				r_pin_d = '{fwd: 1'b1, duty: dmpsc_pkg::DUTY_FULL};
			end
			dmpsc_pkg::OP_ENABLE: begin
				en_d = 1'b1;
			end
			default: begin
				en_d = en_q;
			end
		endcase
	end

	// command state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_tgt_q <= '0;
			r_tgt_q <= '0;
			l_cur_q <= '0;
			r_cur_q <= '0;
			en_q    <= 1'b0;
			l_pin_q <= '0;
			r_pin_q <= '0;
		end else if (adv) begin
			l_tgt_q <= l_tgt_d;
			r_tgt_q <= r_tgt_d;
			l_cur_q <= l_cur_d;
			r_cur_q <= r_cur_d;
			en_q    <= en_d;
			l_pin_q <= l_pin_d;
			r_pin_q <= r_pin_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= '{standby: en_d, left: l_pin_d, right: r_pin_d};
		end
	end

	assign result.valid         = res_vld_q;
	assign result.standby_on    = res_q.standby;
	assign result.left_forward  = res_q.left.fwd;
	assign result.left_duty     = res_q.left.duty;
	assign result.right_forward = res_q.right.fwd;
	assign result.right_duty    = res_q.right.duty;

endmodule

[sv/dmpsc_checker.sv]
// port-level checks of the motor commander and their binding
`include "dual_motor_pwm_slew_commander_defines.svh"

module dmpsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       standby_on,
	input logic       left_forward,
	input logic [7:0] left_duty,
	input logic       right_forward,
	input logic [7:0] right_duty
);

	// a stalled result stays offered
	`DMPSC_ASSERT_NEXT(a_res_hold, out_valid && !out_ready, out_valid)

	// a stalled result keeps its duties
	`DMPSC_ASSERT_NEXT(a_res_stable, out_valid && !out_ready, $stable(left_duty) && $stable(right_duty))

	// a stalled result keeps standby and both direction pins
	`DMPSC_ASSERT_NEXT(a_res_pins, out_valid && !out_ready, $stable({standby_on, left_forward, right_forward}))

	// with standby off the channels are either idle or braking at full duty
	`DMPSC_ASSERT_IMPL(a_standby_off, out_valid && !standby_on, (left_duty == 8'd0 || (left_forward && left_duty == 8'hFF)) && (right_duty == 8'd0 || (right_forward && right_duty == 8'hFF)))

endmodule

bind dual_motor_pwm_slew_commander dmpsc_checker u_dmpsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.standby_on    (result.standby_on),
	.left_forward  (result.left_forward),
	.left_duty     (result.left_duty),
	.right_forward (result.right_forward),
	.right_duty    (result.right_duty)
);

[verif/tb.sv]
// testbench of the dual motor pwm slew commander: directed edges, ramp sweeps, random traffic
module tb;

	localparam int STALL_LIMIT = 1000;
	localparam int REPORT_MAX  = 10;

	logic clk;
	logic arst_n;

	dmpsc_item_if   item_ch();
	dmpsc_result_if result_ch();
	dmpsc_cfg_if    cfg_ch();

	dual_motor_pwm_slew_commander dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// predicted commander state
	dmpsc_pkg::cmd_t  left_target;
	dmpsc_pkg::cmd_t  right_target;
	dmpsc_pkg::cmd_t  left_now;
	dmpsc_pkg::cmd_t  right_now;
	dmpsc_pkg::pins_t pins_now;
	int               ramp_now;

	dmpsc_pkg::pins_t expected_pins[$];
	int    mismatches = 0;
	int    items_sent = 0;
	int    hold_cycles = 0;
	int    quiet_cycles = 0;
	bit    sender_steady = 1'b0;
	bit    receiver_steady = 1'b0;

	// clock, period 4
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// saturate to the command range
	function automatic dmpsc_pkg::cmd_t limit_cmd(input int v);
		if (v > 255) begin
			return dmpsc_pkg::CMD_MAX;
		end
		if (v < -255) begin
			return dmpsc_pkg::CMD_MIN;
		end
		return dmpsc_pkg::cmd_t'(v);
	endfunction

	// sign-magnitude levels of one channel
	function automatic dmpsc_pkg::pin_t levels_of(input dmpsc_pkg::cmd_t c);
		dmpsc_pkg::pin_t p;
		int              mag;
		mag = (c < 0) ? -int'(c) : int'(c);
		p.fwd = (c > 0);
		p.duty = mag[7:0];
		return p;
	endfunction

	// one tick of movement toward the target
	function automatic dmpsc_pkg::cmd_t slew_toward(input dmpsc_pkg::cmd_t cur,
		input dmpsc_pkg::cmd_t tgt, input int step);
		int diff;
		diff = int'(tgt) - int'(cur);
		if (diff <= step && diff >= -step) begin
			return tgt;
		end
		return (diff > 0) ? dmpsc_pkg::cmd_t'(int'(cur) + step)
			: dmpsc_pkg::cmd_t'(int'(cur) - step);
	endfunction

	task automatic command_both(input int l, input int r);
		pins_now.standby = 1'b1;
		left_target = limit_cmd(l);
		right_target = limit_cmd(r);
		left_now = left_target;
		right_now = right_target;
		pins_now.left = levels_of(left_now);
		pins_now.right = levels_of(right_now);
	endtask

	task automatic halt_all();
		pins_now.standby = 1'b0;
		left_target = '0;
		right_target = '0;
		left_now = '0;
		right_now = '0;
		pins_now.left.duty = '0;
		pins_now.right.duty = '0;
	endtask

	// advance the predicted state by one operation and queue the pin levels
	task automatic step_commander(input dmpsc_pkg::op_t op, input logic signed [15:0] a,
		input logic signed [15:0] b);
		int lin;
		int ang;
		case (op)
			dmpsc_pkg::OP_TICK: begin
				if (pins_now.standby) begin
					left_now = slew_toward(left_now, left_target, ramp_now);
					right_now = slew_toward(right_now, right_target, ramp_now);
					pins_now.left = levels_of(left_now);
					pins_now.right = levels_of(right_now);
				end
			end
			dmpsc_pkg::OP_SET_LEFT: left_target = limit_cmd(a);
			dmpsc_pkg::OP_SET_RIGHT: right_target = limit_cmd(b);
			dmpsc_pkg::OP_SET_BOTH: command_both(a, b);
			dmpsc_pkg::OP_TWIST: begin
				lin = int'(a) / 2;
				ang = int'(b) / 10;
				command_both(lin - ang, lin + ang);
			end
			dmpsc_pkg::OP_STOP: halt_all();
			dmpsc_pkg::OP_BRAKE: begin
				halt_all();
				pins_now.left.fwd = 1'b1;
				pins_now.right.fwd = 1'b1;
				pins_now.left.duty = dmpsc_pkg::DUTY_FULL;
				pins_now.right.duty = dmpsc_pkg::DUTY_FULL;
			end
			default: pins_now.standby = 1'b1;
		endcase
		expected_pins.push_back(pins_now);
	endtask

	// offer one transaction, predict once it is taken
	task automatic send_item(input dmpsc_pkg::op_t op, input logic signed [15:0] a,
		input logic signed [15:0] b);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.operation <= op;
		item_ch.first_value <= a;
		item_ch.second_value <= b;
		do @(posedge clk); while (!item_ch.ready);
		step_commander(op, a, b);
		items_sent++;
	endtask

	// stop offering and wait for every pending result
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		wait (expected_pins.size() == 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_ramp(input logic [7:0] v);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		ramp_now = (v == 8'd0) ? 1 : int'(v);
	endtask

	// mix of full range, near the clamp, small and extreme values
	function automatic logic signed [15:0] pick_value();
		logic signed [15:0] v;
		case ($urandom_range(0, 5))
			0: v = 16'($urandom);
			1: v = 16'(int'($urandom_range(0, 600)) - 300);
			2: v = 16'(int'($urandom_range(0, 40)) - 20);
			3: v = 16'(int'($urandom_range(0, 6000)) - 3000);
			4: begin
				case ($urandom_range(0, 5))
					0: v = 16'sh7FFF;
					1: v = 16'sh8000;
					2: v = 16'sd255;
					3: v = -16'sd255;
					4: v = 16'sd256;
					default: v = -16'sd256;
				endcase
			end
			default: v = 16'($urandom_range(0, 255));
		endcase
		return v;
	endfunction

	// enable or jump, retarget, then a run of ticks, sometimes ended by stop, brake or twist
	task automatic slew_burst();
		int ticks;
		if ($urandom_range(0, 1)) begin
			send_item(dmpsc_pkg::OP_ENABLE, pick_value(), pick_value());
		end else begin
			send_item(dmpsc_pkg::OP_SET_BOTH, pick_value(), pick_value());
		end
		if ($urandom_range(0, 3) != 0) begin
			send_item(dmpsc_pkg::OP_SET_LEFT, pick_value(), pick_value());
		end
		if ($urandom_range(0, 3) != 0) begin
			send_item(dmpsc_pkg::OP_SET_RIGHT, pick_value(), pick_value());
		end
		ticks = $urandom_range(1, 12);
		repeat (ticks) send_item(dmpsc_pkg::OP_TICK, pick_value(), pick_value());
		case ($urandom_range(0, 5))
			0: send_item(dmpsc_pkg::OP_STOP, pick_value(), pick_value());
			1: send_item(dmpsc_pkg::OP_BRAKE, pick_value(), pick_value());
			2: send_item(dmpsc_pkg::OP_TWIST, pick_value(), pick_value());
			default: ;
		endcase
	endtask

	// field extremes and every operation, including ticks with standby off
	task automatic test_directed_edges();
		send_item(dmpsc_pkg::OP_TICK, 16'sd0, 16'sd0);
		send_item(dmpsc_pkg::OP_SET_LEFT, 16'sd300, 16'sd0);
		send_item(dmpsc_pkg::OP_SET_RIGHT, 16'sd0, 16'sh8000);
		send_item(dmpsc_pkg::OP_TICK, 16'sd0, 16'sd0);
		send_item(dmpsc_pkg::OP_ENABLE, 16'sd0, 16'sd0);
		send_item(dmpsc_pkg::OP_TICK, 16'sh7FFF, 16'sh8000);
		send_item(dmpsc_pkg::OP_SET_BOTH, 16'sh7FFF, 16'sh8000);
		send_item(dmpsc_pkg::OP_SET_BOTH, 16'sd0, 16'sd0);
		send_item(dmpsc_pkg::OP_SET_BOTH, 16'sd1, -16'sd1);
		send_item(dmpsc_pkg::OP_SET_BOTH, 16'sd256, -16'sd256);
		send_item(dmpsc_pkg::OP_SET_BOTH, -16'sd255, 16'sd255);
		send_item(dmpsc_pkg::OP_TWIST, 16'sh7FFF, 16'sd0);
		send_item(dmpsc_pkg::OP_TWIST, 16'sh8000, 16'sh7FFF);
		send_item(dmpsc_pkg::OP_TWIST, 16'sd1, 16'sd9);
		send_item(dmpsc_pkg::OP_TWIST, -16'sd1, -16'sd19);
		send_item(dmpsc_pkg::OP_TWIST, -16'sd7, 16'sd25);
		send_item(dmpsc_pkg::OP_TWIST, 16'sd0, 16'sh8000);
		send_item(dmpsc_pkg::OP_STOP, 16'sh7FFF, 16'sh7FFF);
		send_item(dmpsc_pkg::OP_TICK, 16'sd0, 16'sd0);
		send_item(dmpsc_pkg::OP_BRAKE, 16'sh8000, 16'sh8000);
		send_item(dmpsc_pkg::OP_ENABLE, 16'sd0, 16'sd0);
		send_item(dmpsc_pkg::OP_TICK, 16'sd0, 16'sd0);
		send_item(dmpsc_pkg::OP_SET_LEFT, 16'sd100, 16'sd0);
		send_item(dmpsc_pkg::OP_TICK, 16'sd0, 16'sd0);
		send_item(dmpsc_pkg::OP_STOP, 16'sd0, 16'sd0);
	endtask

	// slewing under a sweep of ramp steps, zero saturating to one
	task automatic test_ramp_settings();
		logic [7:0] step;
		for (int i = 0; i < 7; i++) begin
			case (i)
				0: step = 8'd1;
				1: step = 8'd0;
				2: step = 8'd255;
				3: step = 8'd128;
				4: step = 8'd3;
				5: step = 8'($urandom_range(2, 254));
				default: step = 8'd255;
			endcase
			write_ramp(step);
			sender_steady = (i % 3 == 0);
			receiver_steady = (i % 3 == 1);
			for (int stop_at = items_sent + 100; items_sent < stop_at; ) begin
				slew_burst();
			end
		end
	endtask

	// bursts mixed with any operation, changing idling from phase to phase
	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			write_ramp(8'($urandom_range(0, 255)));
			sender_steady = ($urandom_range(0, 3) == 0);
			receiver_steady = ($urandom_range(0, 3) == 0);
			for (int stop_at = items_sent + 175; items_sent < stop_at; ) begin
				if ($urandom_range(0, 9) < 7) begin
					slew_burst();
				end else begin
					send_item(dmpsc_pkg::op_t'($urandom_range(0, 7)), pick_value(),
						pick_value());
				end
			end
		end
	endtask

	// long receiver hold while items keep coming, so the input stalls
	task automatic test_output_backpressure();
		settle();
		sender_steady = 1'b1;
		receiver_steady = 1'b0;
		repeat (2) begin
			hold_cycles = 60 + $urandom_range(0, 60);
			for (int stop_at = items_sent + 75; items_sent < stop_at; ) begin
				slew_burst();
			end
		end
		sender_steady = 1'b0;
	endtask

	// result receiver with random stalls and the occasional long hold
	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = receiver_steady ? 0 : $urandom_range(0, 14);
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	// compare each result transaction with the oldest predicted pin levels
	always @(posedge clk) begin : check_results
		dmpsc_pkg::pins_t got;
		dmpsc_pkg::pins_t want;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			got = {result_ch.standby_on, result_ch.left_forward, result_ch.left_duty,
				result_ch.right_forward, result_ch.right_duty};
			if (expected_pins.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("unexpected result: sb=%b lf=%b ld=%0d rf=%b rd=%0d",
						got.standby, got.left.fwd, got.left.duty, got.right.fwd,
						got.right.duty);
				end
			end else begin
				want = expected_pins.pop_front();
				if (got.standby !== want.standby || got.left.fwd !== want.left.fwd
					|| got.left.duty !== want.left.duty
					|| got.right.fwd !== want.right.fwd
					|| got.right.duty !== want.right.duty) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("mismatch exp: sb=%b lf=%b ld=%0d rf=%b rd=%0d",
							want.standby, want.left.fwd, want.left.duty,
							want.right.fwd, want.right.duty);
						$display("         got: sb=%b lf=%b ld=%0d rf=%b rd=%0d",
							got.standby, got.left.fwd, got.left.duty,
							got.right.fwd, got.right.duty);
					end
				end
			end
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// reset, tests in turn, final verdict
	initial begin
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.operation <= dmpsc_pkg::OP_TICK;
		item_ch.first_value <= '0;
		item_ch.second_value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		ramp_now = int'(dmpsc_pkg::RAMP_RESET);
		left_target = '0;
		right_target = '0;
		left_now = '0;
		right_now = '0;
		pins_now = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_ramp_settings();
		test_random_traffic();
		test_output_backpressure();
		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_pins.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/dmpsc_pkg.sv
sv/dmpsc_item_if.sv
sv/dmpsc_result_if.sv
sv/dmpsc_cfg_if.sv
sv/dmpsc_slew.sv
sv/dual_motor_pwm_slew_commander.sv
sv/dmpsc_checker.sv
verif/tb.sv
